@@ src/sgcf_pkg.sv @@
`timescale 1ns / 1ps

package sgcf_pkg;

  // frame layout and byte codes
  localparam int unsigned FRAME_LEN = 4;
  localparam logic [7:0] END_BYTE = 8'd10;
  localparam logic [7:0] OP_CLEAR = 8'h00;
  localparam logic [7:0] OP_SET = 8'h01;

  // reply codes
  localparam logic RESP_ACK = 1'b0;
  localparam logic RESP_NACK = 1'b1;

  // command queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // command class decided by the front end
  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_SET,
    CMD_NACK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] idx;
  } cmd_t;

  // queue handshake between front and back
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

@@ src/serial_gpio_command_framer.sv @@
`timescale 1ns / 1ps

// Serial GPIO command framer. Takes one received byte per cycle on the input
// beat unless stalled; a newline closes the frame, and a frame whose check
// byte matches is executed and answered with one output beat (ACK or NACK
// plus the sixteen low pin levels) through the queue and the output register.
// Frames with a bad check give no beat. The front end collects bytes and
// classifies frames, the back end updates the pins, and a two-entry command
// queue between them absorbs output stalls; the input stalls only while
// the queue is full, which takes a stalled output plus two more valid frames.
module serial_gpio_command_framer #(
  parameter int NUM_PINS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        response,
  output logic [15:0] pin_levels
);

  sgcf_pkg::cmd_t    front_cmd;
  sgcf_pkg::cmd_t    head_cmd;
  sgcf_pkg::q_ctrl_t q_ctrl;
  sgcf_pkg::q_stat_t q_stat;
  logic              q_push;
  logic              q_pop;

  // queue controls come from both ends
  assign q_ctrl = '{push: q_push, pop: q_pop};

  sgcf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_stat.full),
    .push     (q_push),
    .cmd      (front_cmd)
  );

  sgcf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (q_ctrl),
    .wr_cmd (front_cmd),
    .stat   (q_stat),
    .rd_cmd (head_cmd)
  );

  sgcf_back #(
    .NUM_PINS (NUM_PINS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_stat.not_empty),
    .cmd         (head_cmd),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .response    (response),
    .pin_levels  (pin_levels)
  );

endmodule

@@ src/sgcf_front.sv @@
`timescale 1ns / 1ps

module sgcf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               q_full,
  output logic               push,
  output sgcf_pkg::cmd_t     cmd
);

  logic [7:0] frame_bytes [sgcf_pkg::FRAME_LEN];
  logic [2:0] byte_count;
  logic       accept;
  logic       is_end;
  logic [9:0] sum;
  logic [7:0] check;

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;
  assign is_end = (rx_byte == sgcf_pkg::END_BYTE);

  // check byte: carry folded back into the low byte
  always_comb begin
    sum = 10'(frame_bytes[0]) + 10'(frame_bytes[1]) + 10'(frame_bytes[2]);
    check = 8'(10'(sum[9:8]) + 10'(sum[7:0]));
  end

  // classify the stored frame
  always_comb begin
    cmd.idx = frame_bytes[1];
    if (frame_bytes[0] == sgcf_pkg::OP_CLEAR) begin
      cmd.kind = sgcf_pkg::CMD_CLEAR;
    end else if (frame_bytes[0] == sgcf_pkg::OP_SET) begin
      cmd.kind = sgcf_pkg::CMD_SET;
    end else begin
      cmd.kind = sgcf_pkg::CMD_NACK;
    end
  end

  assign push = accept && is_end && (check == frame_bytes[3]);

  // frame collection, extra bytes past the fourth are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      for (int i = 0; i < sgcf_pkg::FRAME_LEN; i++) begin
        frame_bytes[i] <= '0;
      end
    end else if (accept) begin
      if (is_end) begin
        byte_count <= '0;
      end else if (byte_count < 3'(sgcf_pkg::FRAME_LEN)) begin
        frame_bytes[byte_count[1:0]] <= rx_byte;
        byte_count <= byte_count + 3'd1;
      end
    end
  end

endmodule

@@ src/sgcf_queue.sv @@
`timescale 1ns / 1ps

module sgcf_queue (
  input  logic               clk,
  input  logic               rst,
  input  sgcf_pkg::q_ctrl_t  ctrl,
  input  sgcf_pkg::cmd_t     wr_cmd,
  output sgcf_pkg::q_stat_t  stat,
  output sgcf_pkg::cmd_t     rd_cmd
);

  sgcf_pkg::cmd_t entries [sgcf_pkg::QUEUE_DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign stat.full = (count == 2'(sgcf_pkg::QUEUE_DEPTH));
  assign stat.not_empty = (count != 2'd0);
  assign rd_cmd = entries[rd_ptr];

  assign do_push = ctrl.push && !stat.full;
  assign do_pop = ctrl.pop && stat.not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/sgcf_back.sv @@
`timescale 1ns / 1ps

module sgcf_back #(
  parameter int NUM_PINS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  sgcf_pkg::cmd_t     cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               response,
  output logic [15:0]        pin_levels
);

  localparam int EXT_W = (NUM_PINS > 16) ? NUM_PINS : 16;

  logic [NUM_PINS-1:0] pin_state;
  logic [NUM_PINS-1:0] pin_state_next;
  logic [EXT_W-1:0]    pin_ext;
  logic                resp_next;

  // take a command whenever the output register is free or draining
  assign pop = q_not_empty && (!out_valid || !out_stall);

  // apply the command, out-of-range pins match no bit
  always_comb begin
    pin_state_next = pin_state;
    resp_next = sgcf_pkg::RESP_ACK;
    unique case (cmd.kind)
      sgcf_pkg::CMD_CLEAR: begin
        for (int i = 0; i < NUM_PINS; i++) begin
          if (cmd.idx == 8'(i)) pin_state_next[i] = 1'b0;
        end
      end
      sgcf_pkg::CMD_SET: begin
        for (int i = 0; i < NUM_PINS; i++) begin
          if (cmd.idx == 8'(i)) pin_state_next[i] = 1'b1;
        end
      end
      default: begin
        resp_next = sgcf_pkg::RESP_NACK;
      end
    endcase
    pin_ext = EXT_W'(pin_state_next);
  end

  // pin state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_state <= '0;
      out_valid <= 1'b0;
      response <= sgcf_pkg::RESP_ACK;
      pin_levels <= '0;
    end else if (pop) begin
      pin_state <= pin_state_next;
      out_valid <= 1'b1;
      response <= resp_next;
      pin_levels <= pin_ext[15:0];
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ src/sgcf_checker.sv @@
`timescale 1ns / 1ps

module sgcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic        response,
  input logic [15:0] pin_levels
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(response) && $stable(pin_levels))
    else $error("stalled result beat changed");

  // pin levels only move together with a result beat
  a_pins_with_beat: assert property (@(posedge clk) disable iff (rst)
    !$stable(pin_levels) |-> out_valid)
    else $error("pin levels changed without a result beat");

  // a nack leaves the pins as they were
  a_nack_keeps_pins: assert property (@(posedge clk) disable iff (rst)
    out_valid && (response == 1'b1) && !$stable(response) |-> $stable(pin_levels))
    else $error("nack beat changed pin levels");

  // one command touches at most one pin
  a_one_pin: assert property (@(posedge clk) disable iff (rst)
    $countones(pin_levels ^ $past(pin_levels)) <= 1)
    else $error("more than one pin changed at once");

endmodule

bind serial_gpio_command_framer sgcf_checker u_sgcf_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned PIN_COUNT = 16;
  localparam int unsigned RANDOM_BYTES = 800;
  localparam int unsigned HOLD_START = 800;
  localparam int unsigned HOLD_LEN = 600;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct {
    logic [7:0]  value;
    int unsigned gap;
  } rx_item_t;

  typedef struct {
    logic        resp;
    logic [15:0] pins;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        response;
  logic [15:0] pin_levels;

  // bytes waiting to be sent and replies waiting to arrive
  rx_item_t    tx_q[$];
  reply_t      reply_q[$];

  // shadow of the framer state
  logic [7:0]  frame_mem[sgcf_pkg::FRAME_LEN];
  int unsigned fill;
  logic [15:0] pin_model;

  int unsigned tx_count;
  int unsigned idle_left;
  logic        gap_done;
  int unsigned stall_left;
  logic        hold_req = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned replies_seen = 0;
  int unsigned bytes_taken = 0;
  int unsigned in_held = 0;

  serial_gpio_command_framer #(
    .NUM_PINS(PIN_COUNT)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .response  (response),
    .pin_levels(pin_levels)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // folded sum of the first three frame bytes
  function automatic logic [7:0] frame_check(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
    logic [9:0] s;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    return s[7:0] + {6'd0, s[9:8]};
  endfunction

  // advance the shadow state by one byte, queue a reply when a frame executes
  function automatic void framer_step(input logic [7:0] b);
    reply_t rep;
    if (b != sgcf_pkg::END_BYTE) begin
      if (fill < sgcf_pkg::FRAME_LEN) begin
        frame_mem[fill] = b;
        fill = fill + 1;
      end
    end else begin
      fill = 0;
      if (frame_check(frame_mem[0], frame_mem[1], frame_mem[2]) == frame_mem[3]) begin
        if (frame_mem[0] == sgcf_pkg::OP_CLEAR || frame_mem[0] == sgcf_pkg::OP_SET) begin
          if (frame_mem[1] < PIN_COUNT)
            pin_model[frame_mem[1][3:0]] = (frame_mem[0] == sgcf_pkg::OP_SET);
          rep.resp = sgcf_pkg::RESP_ACK;
        end else begin
          rep.resp = sgcf_pkg::RESP_NACK;
        end
        rep.pins = pin_model;
        reply_q.push_back(rep);
      end
    end
  endfunction

  function automatic logic [7:0] rand_data();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == sgcf_pkg::END_BYTE);
    return v;
  endfunction

  // third byte chosen so that neither it nor the check ends the frame early
  function automatic logic [7:0] pick_b2(input logic [7:0] op, input logic [7:0] idx);
    logic [7:0] v;
    do v = rand_data(); while (frame_check(op, idx, v) == sgcf_pkg::END_BYTE);
    return v;
  endfunction

  // queue one byte; every third block of 100 bytes goes without gaps
  task automatic push_byte(input logic [7:0] v);
    rx_item_t it;
    it.value = v;
    it.gap = (((tx_count / 100) % 3) == 2) ? 0 : $urandom_range(0, 9);
    tx_q.push_back(it);
    tx_count = tx_count + 1;
  endtask

  task automatic push_frame(input logic [7:0] op, input logic [7:0] idx, input logic [7:0] b2,
                            input bit bad, input int unsigned extra);
    logic [7:0] chk;
    chk = frame_check(op, idx, b2);
    if (bad) begin
      chk = chk + 8'd1;
      if (chk == sgcf_pkg::END_BYTE) chk = chk + 8'd1;
    end
    push_byte(op);
    push_byte(idx);
    push_byte(b2);
    push_byte(chk);
    repeat (extra) push_byte(rand_data());
    push_byte(sgcf_pkg::END_BYTE);
  endtask

  task automatic push_good_frame(input bit bad);
    logic [7:0] op;
    logic [7:0] idx;
    if ($urandom_range(0, 9) != 0)
      op = ($urandom_range(0, 1) != 0) ? sgcf_pkg::OP_SET : sgcf_pkg::OP_CLEAR;
    else op = rand_data();
    if ($urandom_range(0, 7) != 0) begin
      do idx = 8'($urandom_range(0, PIN_COUNT - 1)); while (idx == sgcf_pkg::END_BYTE);
    end else begin
      idx = 8'($urandom_range(PIN_COUNT, 255));
    end
    push_frame(op, idx, pick_b2(op, idx), bad, 0);
  endtask

  // stimulus
  initial begin
    int unsigned kind;
    int unsigned n;
    tx_count = 0;

    // empty frame right after reset runs the all-zero command
    push_byte(sgcf_pkg::END_BYTE);
    push_frame(sgcf_pkg::OP_SET, 8'd15, 8'hFF, 1'b0, 0);
    push_frame(sgcf_pkg::OP_CLEAR, 8'd15, 8'h00, 1'b0, 0);
    push_frame(sgcf_pkg::OP_SET, 8'hFF, pick_b2(sgcf_pkg::OP_SET, 8'hFF), 1'b0, 0);
    push_frame(8'hFF, 8'd3, pick_b2(8'hFF, 8'd3), 1'b0, 0);
    push_frame(sgcf_pkg::OP_SET, 8'd4, pick_b2(sgcf_pkg::OP_SET, 8'd4), 1'b1, 0);
    // reuses the bad frame, so nothing comes back
    push_byte(sgcf_pkg::END_BYTE);
    push_frame(sgcf_pkg::OP_SET, 8'd7, pick_b2(sgcf_pkg::OP_SET, 8'd7), 1'b0, 2);
    // repeats the long frame's command
    push_byte(sgcf_pkg::END_BYTE);

    // random mix, mostly well-formed frames
    while (tx_count < RANDOM_BYTES + 35) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        push_good_frame(1'b0);
      end else if (kind < 70) begin
        push_good_frame(1'b1);
      end else if (kind < 78) begin
        push_frame(sgcf_pkg::OP_SET, 8'($urandom_range(0, 9)), rand_data(), 1'b0, 0);
        push_frame(rand_data(), rand_data(), rand_data(), 1'b0, $urandom_range(1, 4));
      end else if (kind < 88) begin
        n = $urandom_range(0, 3);
        repeat (n) push_byte(rand_data());
        push_byte(sgcf_pkg::END_BYTE);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
      end
    end
  end

  // reset, then wait for the traffic to drain
  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (tx_q.size() != 0 || in_valid) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bytes, checked %0d replies, input held off for %0d cycles",
             bytes_taken, replies_seen, in_held);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // cycle count, long output hold-off and timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == HOLD_START) hold_req <= 1'b1;
    else if (cycle_cnt == HOLD_START + HOLD_LEN) hold_req <= 1'b0;
    if (in_valid && in_stall) in_held <= in_held + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_left <= 0;
      gap_done <= 1'b0;
      fill = 0;
      pin_model = '0;
      for (int i = 0; i < sgcf_pkg::FRAME_LEN; i++) frame_mem[i] = 8'd0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        framer_step(rx_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (idle_left != 0) begin
        in_valid <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (tx_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (tx_q[0].gap != 0 && !gap_done) begin
        in_valid <= 1'b0;
        idle_left <= tx_q[0].gap - 1;
        gap_done <= 1'b1;
      end else begin
        in_valid <= 1'b1;
        rx_byte <= tx_q[0].value;
        void'(tx_q.pop_front());
        gap_done <= 1'b0;
      end
    end
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < REPORT_MAX) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    mismatches = mismatches + 1;
  endtask

  // reply monitor and output stall
  always @(posedge clk) begin : receive
    int unsigned n;
    reply_t exp;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      n = stall_left;
      if (out_valid && !out_stall) begin
        replies_seen <= replies_seen + 1;
        if (reply_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected reply response=%0b pins=%04h",
                                  response, pin_levels));
        end else begin
          exp = reply_q.pop_front();
          if (response !== exp.resp)
            flag_mismatch($sformatf("response expected %0b got %0b", exp.resp, response));
          if (pin_levels !== exp.pins)
            flag_mismatch($sformatf("pin_levels expected %04h got %04h", exp.pins,
                                    pin_levels));
        end
        // stall-free stretches alternate with random ones
        n = cycle_cnt[8] ? 0 : $urandom_range(0, 9);
      end else if (n != 0) begin
        n = n - 1;
      end
      stall_left <= n;
      out_stall <= hold_req || (n != 0);
    end
  end

endmodule
